FILE: sv/combination_rank_colex_defines.svh
// Assertion macros shared by the combination_rank_colex RTL.
// No dependencies; the macros expect clk and rst_n in the enclosing module.
`ifndef COMBINATION_RANK_COLEX_DEFINES_SVH
`define COMBINATION_RANK_COLEX_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("combination_rank_colex: check failed");

// next-cycle implication
`define CRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("combination_rank_colex: check failed");

`else

`define CRC_ASSERT_IMP(lbl, ante, cons)
`define CRC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/crcolex_pkg.sv
// Package for combination_rank_colex: widths, binomial table geometry, types.
// No dependencies.
package crcolex_pkg;

    // bit positions that take part in the rank
    localparam int WIDTH    = 64;
    localparam int POS_W    = $clog2(WIDTH);
    localparam int PAT_W    = 64;
    localparam int WEIGHT_W = 7;
    localparam int RANK_W   = 61;

    // binomial table C(m, p), addressed {m, p}
    localparam int TBL_AW    = 2 * POS_W;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_SCAN,
        WS_DRAIN
    } walk_state_t;

    // table write port
    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] addr;
        logic [RANK_W-1:0] data;
    } tbl_wr_t;

endpackage

FILE: sv/crcolex_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crcolex_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/crcolex_fill.sv
// Builds Pascal's triangle in the binomial table after reset, one entry a cycle.
// Depends on crcolex_pkg and combination_rank_colex_defines.svh.
`include "combination_rank_colex_defines.svh"

module crcolex_fill
    import crcolex_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    output logic              busy,
    output logic [TBL_AW-1:0] tbl_raddr,
    input  logic [RANK_W-1:0] tbl_rdata,
    output tbl_wr_t           tbl_wr
);

    logic              run_reg, run_next;
    logic [TBL_AW-1:0] idx_reg, idx_next;
    logic              wv_reg;
    logic [TBL_AW-1:0] widx_reg;
    logic [RANK_W-1:0] prev_reg;
    logic [POS_W-1:0]  wn;
    logic [POS_W-1:0]  wr;
    logic [RANK_W-1:0] wr_data;

    // sweep counter over {n, r}
    always_comb
    begin
        run_next = run_reg && (idx_reg != '1);
        idx_next = run_reg ? idx_reg + TBL_AW'(1) : idx_reg;
    end

    // read C(n-1, r) while sweeping entry (n, r); row 0 never uses it
    assign tbl_raddr = {idx_reg[TBL_AW-1:POS_W] - POS_W'(1), idx_reg[POS_W-1:0]};

    // entry value: edges are one, above the diagonal zero, else sum of two above
    assign wn = widx_reg[TBL_AW-1:POS_W];
    assign wr = widx_reg[POS_W-1:0];

    always_comb
    begin
        if (wr == '0 || wr == wn)
        begin
            wr_data = RANK_W'(1);
        end
        else if (wr > wn)
        begin
            wr_data = '0;
        end
        else
        begin
            wr_data = prev_reg + tbl_rdata;
        end
    end

    assign tbl_wr = '{we: wv_reg, addr: widx_reg, data: wr_data};
    assign busy   = run_reg | wv_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b1;
            idx_reg <= '0;
            wv_reg  <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            idx_reg <= idx_next;
            wv_reg  <= run_reg;
        end
    end

    // write stage payload; prev holds C(n-1, r-1)
    always_ff @(posedge clk)
    begin
        widx_reg <= idx_reg;
        prev_reg <= tbl_rdata;
    end

    `CRC_ASSERT_NEXT(a_fill_once, !busy, !busy)
    `CRC_ASSERT_NEXT(a_wr_follows_rd, run_reg, wv_reg)
    `CRC_ASSERT_NEXT(a_wr_addr_pipe, run_reg, widx_reg == $past(idx_reg))

endmodule

FILE: sv/crcolex_walk.sv
// Rank sequencer: scans positions from the top, one table lookup and one add a cycle.
// Depends on crcolex_pkg and combination_rank_colex_defines.svh.
`include "combination_rank_colex_defines.svh"

module crcolex_walk
    import crcolex_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [PAT_W-1:0]    pattern,
    output logic                busy,
    output logic [TBL_AW-1:0]   tbl_raddr,
    input  logic [RANK_W-1:0]   tbl_rdata,
    output logic [RANK_W-1:0]   rank,
    output logic                done
);

    walk_state_t         state_reg, state_next;
    logic [WIDTH-1:0]    pat_reg, pat_next;
    logic [WEIGHT_W-1:0] p_reg, p_next;
    logic [POS_W-1:0]    m_reg, m_next;
    logic                hit_reg, hit_next;
    logic [RANK_W-1:0]   acc_reg, acc_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic                done_reg, done_next;

    logic                take;
    logic                in_range;
    logic [RANK_W-1:0]   sum;

    // current position is set and still has a subset slot left
    assign take     = pat_reg[WIDTH-1] && (p_reg != '0);
    assign in_range = p_reg <= {{(WEIGHT_W-POS_W){1'b0}}, m_reg};

    // shared adder: accumulate last cycle's lookup
    assign sum = acc_reg + (hit_reg ? tbl_rdata : '0);

    assign tbl_raddr = {m_reg, p_reg[POS_W-1:0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WS_IDLE:
            begin
                if (go)
                begin
                    state_next = WS_SCAN;
                end
            end
            WS_SCAN:
            begin
                if (m_reg == '0)
                begin
                    state_next = WS_DRAIN;
                end
            end
            WS_DRAIN:
            begin
                state_next = WS_IDLE;
            end
            default:
            begin
                state_next = WS_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pat_next  = pat_reg;
        p_next    = p_reg;
        m_next    = m_reg;
        hit_next  = 1'b0;
        acc_next  = acc_reg;
        rank_next = rank_reg;
        done_next = 1'b0;
        unique case (state_reg)
            WS_IDLE:
            begin
                if (go)
                begin
                    pat_next = pattern[WIDTH-1:0];
                    p_next   = weight;
                    m_next   = POS_W'(WIDTH - 1);
                    acc_next = '0;
                end
            end
            WS_SCAN:
            begin
                pat_next = pat_reg << 1;
                m_next   = m_reg - POS_W'(1);
                hit_next = take && in_range;
                acc_next = sum;
                if (take)
                begin
                    p_next = p_reg - WEIGHT_W'(1);
                end
            end
            WS_DRAIN:
            begin
                rank_next = sum;
                done_next = 1'b1;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != WS_IDLE);
    assign rank = rank_reg;
    assign done = done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WS_IDLE;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pat_reg  <= pat_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        acc_reg  <= acc_next;
        rank_reg <= rank_next;
    end

    `CRC_ASSERT_NEXT(a_scan_ends, state_reg == WS_SCAN && m_reg == '0, state_reg == WS_DRAIN)
    `CRC_ASSERT_NEXT(a_drain_done, state_reg == WS_DRAIN, done_reg && state_reg == WS_IDLE)
    `CRC_ASSERT_IMP(a_idle_no_hit, state_reg == WS_IDLE, !hit_reg)
    `CRC_ASSERT_NEXT(a_slots_fall, state_reg == WS_SCAN, p_reg <= $past(p_reg))

endmodule

FILE: sv/combination_rank_colex.sv
// Top level of combination_rank_colex: colex rank of a k-subset bit pattern.
// Depends on crcolex_pkg, crcolex_ram, crcolex_fill, crcolex_walk.
//
//  channel   ports                      handshake
//  -------   -------------------------  --------------------------------
//  request   weight, pattern            start high while busy low
//  result    rank                       done high for one cycle
//
// A transaction scans every position from the top after the accepting edge
// (one table read and one add per position); the drain state adds the last
// lookup, and done comes with the registered result. After reset the binomial
// table is built one entry a cycle; busy stays high meanwhile.
// The receiver cannot stall: rank is valid only in the cycle done is high.
module combination_rank_colex
    import crcolex_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [PAT_W-1:0]    pattern,
    output logic [RANK_W-1:0]   rank,
    output logic                done
);

    logic              fill_busy;
    logic              walk_busy;
    logic              go;
    logic [TBL_AW-1:0] fill_raddr;
    logic [TBL_AW-1:0] walk_raddr;
    logic [TBL_AW-1:0] tbl_raddr;
    logic [RANK_W-1:0] tbl_rdata;
    tbl_wr_t           tbl_wr;

    assign busy = fill_busy | walk_busy;
    assign go   = start & ~busy;

    // table read port belongs to the fill sweep until it finishes
    assign tbl_raddr = fill_busy ? fill_raddr : walk_raddr;

    crcolex_ram #(
        .DATA_W (RANK_W),
        .DEPTH  (TBL_DEPTH)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_wr.we),
        .waddr (tbl_wr.addr),
        .wdata (tbl_wr.data),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    crcolex_fill u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .busy      (fill_busy),
        .tbl_raddr (fill_raddr),
        .tbl_rdata (tbl_rdata),
        .tbl_wr    (tbl_wr)
    );

    crcolex_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .weight    (weight),
        .pattern   (pattern),
        .busy      (walk_busy),
        .tbl_raddr (walk_raddr),
        .tbl_rdata (tbl_rdata),
        .rank      (rank),
        .done      (done)
    );

endmodule
